### rtl/cdo_pkg.sv
// Shared types, constants and month-length helper for the date offset unit.
package cdo_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 16;

    localparam logic [YEAR_W-1:0] MAX_YEAR = 14'd9999;
    localparam logic [YEAR_W-1:0] MIN_YEAR = 14'd1;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    localparam logic ACTION_ADD = 1'b0;
    localparam logic ACTION_SUB = 1'b1;

    // Position of a year within the 400-year Gregorian cycle
    localparam logic [8:0] CYCLE_LAST = 9'd399;
    localparam logic [8:0] CENTURY_1  = 9'd100;
    localparam logic [8:0] CENTURY_2  = 9'd200;
    localparam logic [8:0] CENTURY_3  = 9'd300;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MOD,
        S_CHECK,
        S_WALK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic div;
        logic mod;
        logic check;
        logic step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic date_ok;
        logic walk_last;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic               action;
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [COUNT_W-1:0] day_count;
    } item_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  result_year;
        logic [MONTH_W-1:0] result_month;
        logic [DAY_W-1:0]   result_day;
        logic               result_valid;
    } result_t;

    // Days in a month; zero for a month code outside January to December
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: len = 5'd31;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

### rtl/cdo_in_if.sv
// Input channel carrying one date offset request item.
interface cdo_in_if
    import cdo_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               action;
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [COUNT_W-1:0] day_count;

    modport source (
        output valid, action, start_year, start_month, start_day, day_count,
        input  ready
    );

    modport sink (
        input  valid, action, start_year, start_month, start_day, day_count,
        output ready
    );
endinterface

### rtl/cdo_out_if.sv
// Output channel carrying one resulting date item.
interface cdo_out_if
    import cdo_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  result_year;
    logic [MONTH_W-1:0] result_month;
    logic [DAY_W-1:0]   result_day;
    logic               result_valid;

    modport source (
        output valid, result_year, result_month, result_day, result_valid,
        input  ready
    );

    modport sink (
        input  valid, result_year, result_month, result_day, result_valid,
        output ready
    );
endinterface

### rtl/cdo_ctrl.sv
// Controller state machine sequencing load, check, month walk and result hand-off.
module cdo_ctrl
    import cdo_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output cmd_t    cmd,
    input  status_t status
);

    state_t state_reg;
    state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance the sequence and issue datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = status.date_ok ? S_WALK : S_DONE;
            end
            S_WALK:
            begin
                cmd.step = 1'b1;
                if (status.walk_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // An invalid date skips the walk
    a_bad_date_skips_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && !status.date_ok) |=> (state_reg == S_DONE))
        else $error("invalid date did not go straight to result");

    // A result is only written into a free output register
    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result written over an untaken item");

    // No new item is taken while one is still in work
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !in_ready)
        else $error("input ready while an item is in work");

endmodule

### rtl/cdo_dp.sv
// Datapath: date registers, 400-year cycle position, month stepper and output register.
module cdo_dp
    import cdo_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    output status_t status,
    input  item_t   item,
    output result_t result,
    output logic    out_valid,
    input  logic    out_ready
);

    logic               sub_reg;
    logic [YEAR_W-1:0]  year_reg,  year_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [DAY_W-1:0]   day_reg,   day_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [5:0]         q400_reg;
    logic [8:0]         yr400_reg, yr400_next;
    logic               ok_reg,    ok_next;
    logic               walk_last;
    result_t            res_reg;
    logic               out_valid_reg;

    logic [15:0]        div_prod;
    logic [YEAR_W-1:0]  mod_prod;
    logic               leap;
    logic [DAY_W-1:0]   cur_len;
    logic [DAY_W-1:0]   prev_len;
    logic [COUNT_W:0]   add_sum;
    logic               date_ok;

    // Year divided by 400: (year / 16) * 41 / 1024 is exact for a 10-bit quotient input
    assign div_prod = 16'(year_reg[YEAR_W-1:4]) * 16'd41;
    assign mod_prod = YEAR_W'(YEAR_W'(q400_reg) * 14'd400);

    // Leap year from the position in the 400-year cycle
    assign leap = (yr400_reg[1:0] == 2'b00) && (yr400_reg != CENTURY_1) &&
                  (yr400_reg != CENTURY_2) && (yr400_reg != CENTURY_3);
    assign cur_len  = month_len(month_reg, leap);
    assign prev_len = month_len(month_reg - 4'd1, leap);
    assign add_sum  = {1'b0, count_reg} + (COUNT_W+1)'(day_reg);

    assign date_ok = (year_reg >= MIN_YEAR) && (year_reg <= MAX_YEAR) &&
                     (month_reg >= MONTH_JAN) && (month_reg <= MONTH_DEC) &&
                     (day_reg != 5'd0) && (day_reg <= cur_len);

    // One month step of the walk
    always_comb
    begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        count_next = count_reg;
        yr400_next = yr400_reg;
        ok_next    = ok_reg;
        walk_last  = 1'b0;
        if (sub_reg == ACTION_ADD)
        begin
            if (add_sum <= (COUNT_W+1)'(cur_len))
            begin
                day_next  = add_sum[DAY_W-1:0];
                walk_last = 1'b1;
            end
            else
            begin
                count_next = count_reg - COUNT_W'(cur_len - day_reg + 5'd1);
                day_next   = 5'd1;
                if (month_reg == MONTH_DEC)
                begin
                    month_next = MONTH_JAN;
                    year_next  = year_reg + 14'd1;
                    yr400_next = (yr400_reg == CYCLE_LAST) ? 9'd0 : yr400_reg + 9'd1;
                    if (year_reg == MAX_YEAR)
                    begin
                        ok_next   = 1'b0;
                        walk_last = 1'b1;
                    end
                end
                else
                begin
                    month_next = month_reg + 4'd1;
                end
            end
        end
        else
        begin
            if (count_reg < COUNT_W'(day_reg))
            begin
                day_next  = day_reg - count_reg[DAY_W-1:0];
                walk_last = 1'b1;
            end
            else
            begin
                count_next = count_reg - COUNT_W'(day_reg);
                if (month_reg == MONTH_JAN)
                begin
                    month_next = MONTH_DEC;
                    day_next   = month_len(MONTH_DEC, 1'b0);
                    year_next  = year_reg - 14'd1;
                    yr400_next = (yr400_reg == 9'd0) ? CYCLE_LAST : yr400_reg - 9'd1;
                    if (year_reg == MIN_YEAR)
                    begin
                        ok_next   = 1'b0;
                        walk_last = 1'b1;
                    end
                end
                else
                begin
                    month_next = month_reg - 4'd1;
                    day_next   = prev_len;
                end
            end
        end
    end

    // Load, prepare and walk the working date
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sub_reg   <= item.action;
            year_reg  <= item.start_year;
            month_reg <= item.start_month;
            day_reg   <= item.start_day;
            count_reg <= item.day_count;
        end
        else if (cmd.step)
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= day_next;
            count_reg <= count_next;
        end
        if (cmd.div)
        begin
            q400_reg <= div_prod[15:10];
        end
        if (cmd.mod)
        begin
            yr400_reg <= 9'(year_reg - mod_prod);
        end
        else if (cmd.step)
        begin
            yr400_reg <= yr400_next;
        end
        if (cmd.check)
        begin
            ok_reg <= date_ok;
        end
        else if (cmd.step)
        begin
            ok_reg <= ok_next;
        end
    end

    // Capture the result; zero the date when out of range or invalid
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            res_reg.result_valid <= ok_reg;
            res_reg.result_year  <= ok_reg ? year_reg  : '0;
            res_reg.result_month <= ok_reg ? month_reg : '0;
            res_reg.result_day   <= ok_reg ? day_reg   : '0;
        end
    end

    // Hold the output item until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.date_ok   = date_ok;
    assign status.walk_last = walk_last;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign result           = res_reg;
    assign out_valid        = out_valid_reg;

    // An invalid result carries an all-zero date
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.result_valid) |->
        (res_reg.result_year == '0 && res_reg.result_month == '0 &&
         res_reg.result_day == '0))
        else $error("invalid result with non-zero date");

    // The walk only runs on a sane month and day
    a_walk_sane: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (day_reg != 5'd0 && month_reg >= MONTH_JAN &&
                      month_reg <= MONTH_DEC))
        else $error("month walk on a broken date");

    // A valid result always names a real month
    a_valid_month: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.result_valid) |->
        (res_reg.result_month >= MONTH_JAN && res_reg.result_month <= MONTH_DEC &&
         res_reg.result_day != 5'd0))
        else $error("valid result with impossible month or day");

endmodule

### rtl/calendar_date_day_offset_unit.sv
// Top level of the Gregorian date offset unit: controller, datapath and channel wiring.
//
// Usage:
//   query  (sink)  : action (0 add, 1 subtract), start_year, start_month, start_day,
//                    day_count. An item is taken when valid and ready are both high.
//   answer (source): result_year, result_month, result_day, result_valid. One answer
//                    item for every query item, in order.
// Timing:
//   One item is worked on at a time. After acceptance the unit works out the year / 400
//   quotient, then the 400-year cycle position, then checks the date, walks the date
//   a month at a time to the final month, and writes the output register once it is
//   free; an invalid date skips the walk. query.ready is high only when idle, so the
//   next query is taken once the controller is back in idle at the earliest, while the
//   previous answer may still wait for its taker.
// Reset: rst_n low clears the controller and the output valid; no answer is pending.
// Stall:
//   A held answer stays stable; a finished item waits in the controller until the
//   output register is free, and no new item is taken meanwhile.
module calendar_date_day_offset_unit
    import cdo_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    cdo_in_if.sink    query,
    cdo_out_if.source answer
);

    cmd_t    cmd;
    status_t status;
    item_t   item;
    result_t result;
    logic    in_ready;
    logic    out_valid;

    // Gather the request fields
    assign item.action      = query.action;
    assign item.start_year  = query.start_year;
    assign item.start_month = query.start_month;
    assign item.start_day   = query.start_day;
    assign item.day_count   = query.day_count;
    assign query.ready      = in_ready;

    cdo_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (query.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    cdo_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .item      (item),
        .result    (result),
        .out_valid (out_valid),
        .out_ready (answer.ready)
    );

    // Drive the answer channel
    assign answer.valid        = out_valid;
    assign answer.result_year  = result.result_year;
    assign answer.result_month = result.result_month;
    assign answer.result_day   = result.result_day;
    assign answer.result_valid = result.result_valid;

endmodule

### verif/tb.sv
// Testbench for the Gregorian date offset unit: random and directed requests, scoreboard check.
`timescale 1ns / 100ps

module tb
    import cdo_pkg::*;
;

    // Predicts each resulting date and checks the answers in order
    class date_scoreboard;
        result_t     expected_q[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        function bit leap_year(int unsigned y);
            if (y % 100 == 0)
                return (y % 400) == 0;
            return (y % 4) == 0;
        endfunction

        function int unsigned days_in_month(int unsigned m, int unsigned y);
            case (m)
                MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
                MONTH_AUG, MONTH_OCT, MONTH_DEC: return 31;
                MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
                MONTH_FEB: return leap_year(y) ? 29 : 28;
                default: return 0;
            endcase
        endfunction

        // Walk the date a month at a time until the count is used up
        function result_t shifted_date(item_t it);
            int unsigned y, m, d, n, len;
            bit          ok;
            bit          walking;
            result_t     r;
            y = it.start_year;
            m = it.start_month;
            d = it.start_day;
            n = it.day_count;
            ok = !(y < MIN_YEAR || y > MAX_YEAR || m < MONTH_JAN || m > MONTH_DEC ||
                   d < 1 || d > days_in_month(m, y));
            walking = ok;
            while (walking)
            begin
                if (it.action == ACTION_ADD)
                begin
                    len = days_in_month(m, y);
                    if (d + n <= len)
                    begin
                        d += n;
                        walking = 0;
                    end
                    else
                    begin
                        n -= len - d + 1;
                        d = 1;
                        m++;
                        if (m > MONTH_DEC)
                        begin
                            m = MONTH_JAN;
                            y++;
                            if (y > MAX_YEAR)
                            begin
                                ok = 0;
                                walking = 0;
                            end
                        end
                    end
                end
                else
                begin
                    if (n < d)
                    begin
                        d -= n;
                        walking = 0;
                    end
                    else
                    begin
                        n -= d;
                        m--;
                        if (m < MONTH_JAN)
                        begin
                            m = MONTH_DEC;
                            y--;
                            if (y < MIN_YEAR)
                            begin
                                ok = 0;
                                walking = 0;
                            end
                        end
                        if (walking)
                            d = days_in_month(m, y);
                    end
                end
            end
            if (!ok)
            begin
                y = 0;
                m = 0;
                d = 0;
            end
            r.result_year  = y[YEAR_W-1:0];
            r.result_month = m[MONTH_W-1:0];
            r.result_day   = d[DAY_W-1:0];
            r.result_valid = ok;
            return r;
        endfunction

        task report_mismatch(string what);
            $display("%0t mismatch: %s", $time, what);
            errors++;
        endtask

        function void note_request(item_t it);
            expected_q.push_back(shifted_date(it));
        endfunction

        task check_answer(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected answer %0d-%0d-%0d valid %0b",
                    got.result_year, got.result_month, got.result_day, got.result_valid));
                return;
            end
            want = expected_q.pop_front();
            if (got.result_year != want.result_year)
                report_mismatch($sformatf("result_year %0d, expected %0d",
                    got.result_year, want.result_year));
            if (got.result_month != want.result_month)
                report_mismatch($sformatf("result_month %0d, expected %0d",
                    got.result_month, want.result_month));
            if (got.result_day != want.result_day)
                report_mismatch($sformatf("result_day %0d, expected %0d",
                    got.result_day, want.result_day));
            if (got.result_valid != want.result_valid)
                report_mismatch($sformatf("result_valid %0b, expected %0b",
                    got.result_valid, want.result_valid));
        endtask

        function int unsigned pending();
            return expected_q.size();
        endfunction

        task close_out();
            if (expected_q.size() != 0)
                report_mismatch($sformatf("%0d answers never arrived", expected_q.size()));
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   no_idle;

    cdo_in_if  query_if ();
    cdo_out_if answer_if ();

    date_scoreboard board = new();

    calendar_date_day_offset_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_if.sink),
        .answer (answer_if.source)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Mostly short gaps, a few long ones; none during quiet stretches
    function automatic int unsigned pick_gap(bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic item_t make_item(logic act, int unsigned y, int unsigned m,
                                        int unsigned d, int unsigned n);
        item_t it;
        it.action      = act;
        it.start_year  = y[YEAR_W-1:0];
        it.start_month = m[MONTH_W-1:0];
        it.start_day   = d[DAY_W-1:0];
        it.day_count   = n[COUNT_W-1:0];
        return it;
    endfunction

    // Mostly well-formed dates, many near the interesting edges, some noise
    function automatic item_t random_item();
        item_t       it;
        int unsigned pick, sel, y, m, d, len, n;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return make_item(1'($urandom_range(0, 1)), $urandom_range(0, 16383),
                             $urandom_range(0, 15), $urandom_range(0, 31),
                             $urandom_range(0, 65535));
        sel = $urandom_range(0, 99);
        if (sel < 15)
            y = $urandom_range(1, 5);
        else if (sel < 30)
            y = $urandom_range(9995, 9999);
        else if (sel < 40)
            y = $urandom_range(1, 99) * 100;
        else
            y = $urandom_range(1, 9999);
        m = $urandom_range(MONTH_JAN, MONTH_DEC);
        len = board.days_in_month(m, y);
        if (pick < 12)
            d = (len == 31) ? 0 : len + 1;
        else if ($urandom_range(0, 4) == 0)
            d = len;
        else
            d = $urandom_range(1, len);
        sel = $urandom_range(0, 99);
        if (sel < 50)
            n = $urandom_range(0, 60);
        else if (sel < 80)
            n = $urandom_range(61, 3000);
        else if (sel < 92)
            n = $urandom_range(3001, 20000);
        else
            n = $urandom_range(20001, 65535);
        return make_item(1'($urandom_range(0, 1)), y, m, d, n);
    endfunction

    // Offer one item after a random gap and hold it until taken
    task automatic send_request(item_t it);
        int unsigned gap;
        gap = pick_gap(no_idle);
        if (gap > 0)
        begin
            query_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        query_if.valid       <= 1'b1;
        query_if.action      <= it.action;
        query_if.start_year  <= it.start_year;
        query_if.start_month <= it.start_month;
        query_if.start_day   <= it.start_day;
        query_if.day_count   <= it.day_count;
        do
            @(posedge clk);
        while (!query_if.ready);
        board.note_request(it);
    endtask

    task automatic send_directed();
        // zero count, leap days and century rules
        send_request(make_item(ACTION_ADD, 2024, MONTH_FEB, 29, 0));
        send_request(make_item(ACTION_ADD, 2024, MONTH_FEB, 28, 1));
        send_request(make_item(ACTION_ADD, 2023, MONTH_FEB, 28, 1));
        send_request(make_item(ACTION_ADD, 1900, MONTH_FEB, 28, 1));
        send_request(make_item(ACTION_ADD, 2000, MONTH_FEB, 28, 1));
        send_request(make_item(ACTION_SUB, 2000, MONTH_MAR, 1, 1));
        send_request(make_item(ACTION_SUB, 1900, MONTH_MAR, 1, 1));
        send_request(make_item(ACTION_ADD, 2024, MONTH_JAN, 31, 31));
        send_request(make_item(ACTION_SUB, 2024, MONTH_DEC, 31, 365));
        // invalid input dates
        send_request(make_item(ACTION_ADD, 1900, MONTH_FEB, 29, 5));
        send_request(make_item(ACTION_ADD, 0, MONTH_JAN, 1, 5));
        send_request(make_item(ACTION_SUB, 10000, MONTH_JAN, 1, 5));
        send_request(make_item(ACTION_ADD, 16383, 15, 31, 65535));
        send_request(make_item(ACTION_ADD, 2020, 0, 10, 5));
        send_request(make_item(ACTION_SUB, 2020, 13, 10, 5));
        send_request(make_item(ACTION_ADD, 2020, MONTH_MAY, 0, 5));
        send_request(make_item(ACTION_ADD, 2020, MONTH_APR, 31, 5));
        // year range limits
        send_request(make_item(ACTION_ADD, 9999, MONTH_DEC, 31, 1));
        send_request(make_item(ACTION_ADD, 9999, MONTH_DEC, 31, 65535));
        send_request(make_item(ACTION_SUB, 1, MONTH_JAN, 1, 1));
        send_request(make_item(ACTION_SUB, 1, MONTH_JAN, 1, 65535));
        send_request(make_item(ACTION_SUB, 1, MONTH_JAN, 1, 0));
        send_request(make_item(ACTION_ADD, 1, MONTH_JAN, 1, 65535));
        send_request(make_item(ACTION_SUB, 9999, MONTH_DEC, 31, 65535));
        send_request(make_item(ACTION_ADD, 9999, MONTH_DEC, 31, 0));
    endtask

    // Reset, stimulus and end of run
    initial
    begin
        rst_n = 1'b0;
        no_idle = 1'b0;
        query_if.valid       <= 1'b0;
        query_if.action      <= ACTION_ADD;
        query_if.start_year  <= '0;
        query_if.start_month <= '0;
        query_if.start_day   <= '0;
        query_if.day_count   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_directed();
        for (int i = 0; i < 270; i++)
        begin
            no_idle = (i >= 100 && i < 140);
            send_request(random_item());
        end
        no_idle = 1'b0;
        query_if.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        board.close_out();
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Stall the answer side at random
    initial
    begin
        int unsigned stall, hold;
        answer_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = pick_gap(no_idle);
            if (stall > 0)
            begin
                answer_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            answer_if.ready <= 1'b1;
            hold = $urandom_range(1, 8);
            repeat (hold) @(posedge clk);
        end
    end

    // Check every answer item taken
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && answer_if.valid && answer_if.ready)
        begin
            got.result_year  = answer_if.result_year;
            got.result_month = answer_if.result_month;
            got.result_day   = answer_if.result_day;
            got.result_valid = answer_if.result_valid;
            board.check_answer(got);
        end
    end

    // Hard stop well beyond the slowest correct run
    initial
    begin
        #60_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### calendar_date_day_offset_unit.f
rtl/cdo_pkg.sv
rtl/cdo_in_if.sv
rtl/cdo_out_if.sv
rtl/cdo_ctrl.sv
rtl/cdo_dp.sv
rtl/calendar_date_day_offset_unit.sv
verif/tb.sv
